// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while reset is low
`define SVPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same on the block clock and reset
`define SVPD_ASSERT_CLK(lbl, prop, msg) `SVPD_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/svpd_pkg.sv
// Package: constants, tables and types of the SVPWM duty block.
`default_nettype none

package svpd_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEPS        = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int DIV_STEPS    = FRAC_BITS + 2;
  localparam int WORK_STEPS   = (STEPS > DIV_STEPS) ? STEPS : DIV_STEPS;
  localparam int CNT_W        = $clog2(WORK_STEPS);

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [30:0] SQRT3_Q30    = 31'd1859775393;
  localparam logic [15:0] RECIP6       = 16'd43691;

  typedef enum logic {
    CFG_SUPPLY = 1'b0,
    CFG_PERIOD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic               vec;
    logic               flip;
    logic               neg;
    logic [16:0]        ax;
    logic signed [16:0] ay;
    logic [15:0]        theta;
  } svpd_item_t;

  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // floor((b * 65536 + 3) / 6) for a remainder b of a division by six
  function automatic logic [15:0] sixth_frac(input logic [2:0] b);
    logic [15:0] v;
    case (b)
      3'd0:    v = 16'd0;
      3'd1:    v = 16'd10923;
      3'd2:    v = 16'd21845;
      3'd3:    v = 16'd32768;
      3'd4:    v = 16'd43691;
      3'd5:    v = 16'd54613;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/svpd_front.sv
// Front end: classify the d/q request and hold it in a two-entry queue.
`default_nettype none

module svpd_front
  import svpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] volt_q_i,
  input  logic [15:0] volt_d_i,
  input  logic [15:0] elec_angle_i,
  output logic        item_valid_o,
  output svpd_item_t  item_o,
  input  logic        item_ready_i
);

  svpd_item_t         entry_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  svpd_item_t         cls;
  logic signed [16:0] q_ext, d_ext, q_abs, d_abs;
  logic               do_push, do_pop;

  always_comb begin
    q_ext     = {volt_q_i[15], volt_q_i};
    d_ext     = {volt_d_i[15], volt_d_i};
    q_abs     = q_ext[16] ? -q_ext : q_ext;
    d_abs     = d_ext[16] ? -d_ext : d_ext;
    cls.vec   = (volt_d_i != 16'd0);
    cls.flip  = volt_d_i[15];
    cls.neg   = volt_q_i[15];
    cls.ax    = cls.vec ? d_abs : q_abs;
    cls.ay    = volt_d_i[15] ? -q_ext : q_ext;
    cls.theta = elec_angle_i;
  end

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// File: hdl/svpd_back.sv
// Back end: CORDIC, divider and duty arithmetic sequencer with result register.
`default_nettype none

module svpd_back
  import svpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  svpd_item_t  item_i,
  output logic        item_ready_o,
  input  logic [14:0] supply_i,
  input  logic [15:0] period_i,
  input  logic        res_take_i,
  output logic        res_valid_o,
  output logic [15:0] duty_a_o,
  output logic [15:0] duty_b_o,
  output logic [15:0] duty_c_o,
  output logic [2:0]  sector_o
);

  localparam int XW    = 36;
  localparam int MAG_W = 34;
  localparam int RW    = 34;
  localparam int ZW    = 33;
  localparam int DW    = FRAC_BITS + 36;
  localparam int DVW   = 31;
  localparam int SW    = FRAC_BITS + 3;
  localparam int PW    = 32 + SW;
  localparam int PSW   = PW - 30;
  localparam int MW    = FRAC_BITS + 2;
  localparam int TPW   = PSW + MW;
  localparam int TW    = TPW - FRAC_BITS + 2;
  localparam int FW    = FRAC_BITS + 1;
  localparam int DUW   = FRAC_BITS + 17;

  localparam logic signed [PW-1:0] SQ3     = PW'(SQRT3_Q30);
  localparam logic signed [RW-1:0] RND     = RW'(1) << (29 - FRAC_BITS);
  localparam logic signed [RW-1:0] INV_R   = RW'(INV_GAIN_Q30);
  localparam logic signed [TW-1:0] ONE_T   = TW'(1) << FRAC_BITS;
  localparam logic signed [MW-1:0] M_MAX   = {1'b0, {(MW-1){1'b1}}};
  localparam logic signed [MW-1:0] M_MIN   = {1'b1, {(MW-1){1'b0}}};
  localparam logic [CNT_W-1:0]     VEC_END  = CNT_W'(STEPS - 1);
  localparam logic [CNT_W-1:0]     WORK_END = CNT_W'(WORK_STEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_VEC, ST_MAGL, ST_MAGH, ST_PREP, ST_SINP, ST_SINZ,
    ST_WORK, ST_MUL1, ST_MUL2, ST_MIX, ST_DUTY
  } state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    vec_q, neg_q;
  logic [16:0]             ax_q;
  logic [15:0]             theta_q;
  logic signed [XW-1:0]    x_q, y_q;
  logic [31:0]             z_q;
  logic [63:0]             acc_q;
  logic [MAG_W-1:0]        mag_q;
  logic [2:0]              sec_q;
  logic [16:0]             phi_q [2];
  logic [16:0]             a_q [2];
  logic signed [RW-1:0]    rx_q [2];
  logic signed [RW-1:0]    ry_q [2];
  logic signed [ZW-1:0]    rz_q [2];
  logic [DW-1:0]           rem_q, dsh_q;
  logic [DIV_STEPS-1:0]    quo_q;
  logic                    ovf_q;
  logic signed [PW-1:0]    p_q [2];
  logic signed [MW-1:0]    m_q;
  logic signed [TPW-1:0]   tp_q [2];
  logic [FW-1:0]           f_q [3];
  logic                    res_valid_q;
  logic [15:0]             duty_q [3];
  logic [2:0]              sector_q;

  logic signed [XW-1:0]    vdx, vdy;
  logic [29:0]             atan_v;
  logic signed [ZW-1:0]    atan_z;
  logic [14:0]             sup_eff;
  logic [DVW-1:0]          dv;
  logic [DW-1:0]           rem_init;
  logic [63:0]             mag_sum;
  logic [15:0]             adv, th;
  logic [18:0]             r6;
  logic [16:0]             phi_n [2];
  logic [16:0]             a_n [2];
  logic [2:0]              b_n [2];
  logic signed [ZW-1:0]    z_n [2];
  logic signed [RW-1:0]    rdx [2];
  logic signed [RW-1:0]    rdy [2];
  logic signed [RW-1:0]    rnd [2];
  logic signed [SW-1:0]    sin_n [2];
  logic signed [PSW-1:0]   ps [2];
  logic signed [MW-1:0]    m_n;
  logic signed [MW-1:0]    quo_s;
  logic signed [TW-1:0]    t1, t2, t0, h, s12, s1h, s2h;
  logic signed [TW-1:0]    fa, fb, fc;
  logic [DUW-1:0]          prod [3];
  logic                    out_free;

  function automatic logic [FW-1:0] clamp_frac(input logic signed [TW-1:0] v);
    logic [FW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ONE_T) begin
      r = FW'(ONE_T);
    end else begin
      r = FW'(v);
    end
    return r;
  endfunction

  always_comb begin
    vdx      = y_q >>> cnt_q;
    vdy      = x_q >>> cnt_q;
    atan_v   = atan_turn(5'(cnt_q));
    atan_z   = ZW'(atan_v);
    sup_eff  = (supply_i == 15'd0) ? 15'd1 : supply_i;
    dv       = vec_q ? (DVW'(sup_eff) << 16) : DVW'(sup_eff);
    rem_init = vec_q ? (DW'(mag_q) << FRAC_BITS) : (DW'(ax_q) << FRAC_BITS);
    mag_sum  = acc_q + ((64'(x_q[33:17]) * 64'(INV_GAIN_Q30)) << 17);
    adv      = vec_q ? 16'((33'(z_q) + 33'h8000) >> 16) : 16'd16384;
    th       = theta_q + adv;
    r6       = 19'(th) * 19'd6;
    phi_n[0] = 17'h10000 - 17'(r6[15:0]);
    phi_n[1] = 17'(r6[15:0]);
    quo_s    = MW'({1'b0, quo_q[DIV_STEPS-2:0]});
    if (ovf_q || quo_q[DIV_STEPS-1]) begin
      m_n = (neg_q && !vec_q) ? M_MIN : M_MAX;
    end else begin
      m_n = (neg_q && !vec_q) ? -quo_s : quo_s;
    end
    for (int k = 0; k < 2; k++) begin
      a_n[k]   = 17'((34'(phi_q[k]) * 34'(RECIP6)) >> 18);
      b_n[k]   = 3'(phi_q[k] - 17'((a_q[k] << 2) + (a_q[k] << 1)));
      z_n[k]   = (ZW'(a_q[k]) << 16) + ZW'(sixth_frac(b_n[k]));
      rdx[k]   = ry_q[k] >>> cnt_q;
      rdy[k]   = rx_q[k] >>> cnt_q;
      rnd[k]   = ry_q[k] + RND;
      sin_n[k] = SW'(rnd[k] >>> (30 - FRAC_BITS));
      ps[k]    = PSW'(p_q[k] >>> 30);
    end
    t1  = TW'(tp_q[0] >>> FRAC_BITS);
    t2  = TW'(tp_q[1] >>> FRAC_BITS);
    t0  = ONE_T - t1 - t2;
    h   = t0 >>> 1;
    s12 = t1 + t2 + h;
    s1h = t1 + h;
    s2h = t2 + h;
    unique case (sec_q)
      3'd1:    begin fa = s12; fb = s2h; fc = h;   end
      3'd2:    begin fa = s1h; fb = s12; fc = h;   end
      3'd3:    begin fa = h;   fb = s12; fc = s2h; end
      3'd4:    begin fa = h;   fb = s1h; fc = s12; end
      3'd5:    begin fa = s2h; fb = h;   fc = s12; end
      default: begin fa = s12; fb = h;   fc = s1h; end
    endcase
    for (int k = 0; k < 3; k++) begin
      prod[k] = DUW'(f_q[k]) * DUW'(period_i);
    end
  end

  assign out_free     = !res_valid_q || res_take_i;
  assign item_ready_o = (state_q == ST_IDLE);
  assign res_valid_o  = res_valid_q;
  assign duty_a_o     = duty_q[0];
  assign duty_b_o     = duty_q[1];
  assign duty_c_o     = duty_q[2];
  assign sector_o     = sector_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if ((state_q == ST_DUTY) && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_take_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            vec_q   <= item_i.vec;
            neg_q   <= item_i.neg;
            ax_q    <= item_i.ax;
            theta_q <= item_i.theta;
            x_q     <= XW'(item_i.ax) << 16;
            y_q     <= XW'(item_i.ay) <<< 16;
            z_q     <= item_i.flip ? 32'h8000_0000 : 32'd0;
            cnt_q   <= '0;
            state_q <= item_i.vec ? ST_VEC : ST_PREP;
          end
        end
        ST_VEC: begin
          if (!y_q[XW-1]) begin
            x_q <= x_q + vdx;
            y_q <= y_q - vdy;
            z_q <= z_q + 32'(atan_v);
          end else begin
            x_q <= x_q - vdx;
            y_q <= y_q + vdy;
            z_q <= z_q - 32'(atan_v);
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == VEC_END) begin
            state_q <= ST_MAGL;
          end
        end
        ST_MAGL: begin
          acc_q   <= 64'(x_q[16:0]) * 64'(INV_GAIN_Q30);
          state_q <= ST_MAGH;
        end
        ST_MAGH: begin
          mag_q   <= mag_sum[63:30];
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          sec_q    <= r6[18:16] + 3'd1;
          phi_q[0] <= phi_n[0];
          phi_q[1] <= phi_n[1];
          rem_q    <= rem_init;
          dsh_q    <= DW'(dv) << (DIV_STEPS - 1);
          ovf_q    <= (rem_init >= (DW'(dv) << DIV_STEPS));
          quo_q    <= '0;
          state_q  <= ST_SINP;
        end
        ST_SINP: begin
          a_q[0]  <= a_n[0];
          a_q[1]  <= a_n[1];
          state_q <= ST_SINZ;
        end
        ST_SINZ: begin
          for (int k = 0; k < 2; k++) begin
            rx_q[k] <= INV_R;
            ry_q[k] <= '0;
            rz_q[k] <= z_n[k];
          end
          cnt_q   <= '0;
          state_q <= ST_WORK;
        end
        ST_WORK: begin
          if (32'(cnt_q) < STEPS) begin
            for (int k = 0; k < 2; k++) begin
              if (!rz_q[k][ZW-1]) begin
                rx_q[k] <= rx_q[k] - rdx[k];
                ry_q[k] <= ry_q[k] + rdy[k];
                rz_q[k] <= rz_q[k] - atan_z;
              end else begin
                rx_q[k] <= rx_q[k] + rdx[k];
                ry_q[k] <= ry_q[k] - rdy[k];
                rz_q[k] <= rz_q[k] + atan_z;
              end
            end
          end
          if (32'(cnt_q) < DIV_STEPS) begin
            if (rem_q >= dsh_q) begin
              rem_q <= rem_q - dsh_q;
              quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
            end else begin
              quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
            end
            dsh_q <= dsh_q >> 1;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == WORK_END) begin
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          p_q[0]  <= SQ3 * PW'(sin_n[0]);
          p_q[1]  <= SQ3 * PW'(sin_n[1]);
          m_q     <= m_n;
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          tp_q[0] <= TPW'(ps[0]) * TPW'(m_q);
          tp_q[1] <= TPW'(ps[1]) * TPW'(m_q);
          state_q <= ST_MIX;
        end
        ST_MIX: begin
          f_q[0]  <= clamp_frac(fa);
          f_q[1]  <= clamp_frac(fb);
          f_q[2]  <= clamp_frac(fc);
          state_q <= ST_DUTY;
        end
        ST_DUTY: begin
          if (out_free) begin
            for (int k = 0; k < 3; k++) begin
              duty_q[k] <= 16'(prod[k] >> FRAC_BITS);
            end
            sector_q    <= sec_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/svpwm_phase_duty_top.sv
// Top level: SVPWM duty calculation with configuration registers.
//
//   channel   direction  handshake            payload
//   request   in         push / full          volt_q_i, volt_d_i, elec_angle_i
//   result    out        empty / pop          duty_a_o, duty_b_o, duty_c_o, sector_o
//   config    in         cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// With volt_d nonzero an item runs the 16-step vectoring CORDIC and then the
// shared 16-step sine CORDIC / divider pass; with volt_d zero it runs only the pass.
// A two-entry request queue keeps taking requests while the back end works.
// One finished result waits in the output register; the back end stalls only
// when a second result is ready and the first is not popped.
// Reset is asynchronous active low and loads supply 12000 and period 3600.
`default_nettype none

module svpwm_phase_duty_top
  import svpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] volt_q_i,
  input  logic [15:0] volt_d_i,
  input  logic [15:0] elec_angle_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] duty_a_o,
  output logic [15:0] duty_b_o,
  output logic [15:0] duty_c_o,
  output logic [2:0]  sector_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [14:0] supply_q;
  logic [15:0] period_q;
  logic        item_valid, item_ready, res_valid;
  svpd_item_t  item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= 15'd12000;
      period_q <= 16'd3600;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SUPPLY: supply_q <= cfg_wdata_i[14:0];
        CFG_PERIOD: period_q <= cfg_wdata_i;
        default:    period_q <= period_q;
      endcase
    end
  end

  svpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .volt_q_i     (volt_q_i),
    .volt_d_i     (volt_d_i),
    .elec_angle_i (elec_angle_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  svpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .supply_i     (supply_q),
    .period_i     (period_q),
    .res_take_i   (pop && res_valid),
    .res_valid_o  (res_valid),
    .duty_a_o     (duty_a_o),
    .duty_b_o     (duty_b_o),
    .duty_c_o     (duty_c_o),
    .sector_o     (sector_o)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

// File: hdl/svpd_checker.sv
// Checker on the top level ports, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module svpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] duty_a_o,
  input logic [15:0] duty_b_o,
  input logic [15:0] duty_c_o,
  input logic [2:0]  sector_o
);

  `SVPD_ASSERT_CLK(a_sector_range, !empty |-> (sector_o != 3'd0 && sector_o != 3'd7), "sector out of range")
  `SVPD_ASSERT_CLK(a_full_after_push, $rose(full) |-> $past(push), "queue filled without a request")
  `SVPD_ASSERT_CLK(a_result_held, (!empty && !pop) |=> !empty, "result dropped before pop")
  `SVPD_ASSERT_CLK(a_result_stable, (!empty && !pop) |=> ($stable(duty_a_o) && $stable(duty_b_o) && $stable(duty_c_o) && $stable(sector_o)), "waiting result changed")

endmodule

bind svpwm_phase_duty_top svpd_checker u_svpd_checker (.*);

`default_nettype wire
